// ===== hdl/pedtbl_pkg.sv =====
// ----------------------------------------------------------------------------
// pedtbl_pkg
// Shared types, widths and codes of the pedigree relationship table.
// ----------------------------------------------------------------------------
package pedtbl_pkg;

    localparam int MAX_INDIVIDUALS = 256;
    localparam int FRACTION_BITS   = 30;
    localparam int IDX_W           = $clog2(MAX_INDIVIDUALS);
    localparam int CNT_W           = IDX_W + 1;
    localparam int ADDR_W          = 2 * IDX_W;
    localparam int WORD_W          = 32;
    localparam int DEPTH           = MAX_INDIVIDUALS * MAX_INDIVIDUALS;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [1:0]        t_status;

    localparam t_word ONE_FIXED = t_word'(1) << FRACTION_BITS;
    localparam t_cnt  MAX_CNT   = t_cnt'(MAX_INDIVIDUALS);

    localparam logic    KIND_ADD   = 1'b0;
    localparam logic    KIND_QUERY = 1'b1;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_FULL       = 2'd1;
    localparam t_status ST_BAD_PARENT = 2'd2;
    localparam t_status ST_BAD_QUERY  = 2'd3;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_mem_req;

    typedef struct packed {
        t_word   relationship;
        t_idx    assigned_index;
        t_status status;
    } t_result;

    // Lower triangle only: row is the larger index.
    function automatic t_addr pair_addr(input t_idx a, input t_idx b);
        pair_addr = (a >= b) ? {a, b} : {b, a};
    endfunction

endpackage

// ===== hdl/pedtbl_mem.sv =====
// ----------------------------------------------------------------------------
// pedtbl_mem
// Relationship store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pedtbl_mem (
    input  logic               i_clk,
    input  pedtbl_pkg::t_mem_req i_req,
    output pedtbl_pkg::t_word  o_rdata_a,
    output pedtbl_pkg::t_word  o_rdata_b
);
    import pedtbl_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata_a;
    t_word r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_req.raddr_a];
        r_rdata_b <= r_mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/pedtbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pedtbl_ctrl
// Sequencer: row fill for adds, pair lookup for queries, status checks.
// ----------------------------------------------------------------------------
module pedtbl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  pedtbl_pkg::t_idx     i_mother_index,
    input  pedtbl_pkg::t_idx     i_father_index,
    input  pedtbl_pkg::t_idx     i_first_index,
    input  pedtbl_pkg::t_idx     i_second_index,
    input  pedtbl_pkg::t_cnt     i_founder_count,
    output pedtbl_pkg::t_mem_req o_mem_req,
    input  pedtbl_pkg::t_word    i_rdata_a,
    input  pedtbl_pkg::t_word    i_rdata_b,
    output logic                 o_res_valid,
    output pedtbl_pkg::t_result  o_res,
    input  logic                 i_res_take
);
    import pedtbl_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SWEEP   = 3'd1;
    localparam logic [2:0] S_DIAG_RD = 3'd2;
    localparam logic [2:0] S_DIAG_WR = 3'd3;
    localparam logic [2:0] S_Q_RD    = 3'd4;
    localparam logic [2:0] S_Q_DAT   = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] r_state;
    t_cnt       r_count;
    t_idx       r_n;
    t_idx       r_pa;
    t_idx       r_pb;
    logic       r_founder;
    t_cnt       r_k;
    logic       r_wv;
    t_idx       r_wk;
    t_result    r_res;

    logic         accept;
    logic         issue;
    t_cnt         n_cnt;
    logic [32:0]  sum;
    logic [32:0]  diag;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign issue = (r_k < {1'b0, r_n});
    assign n_cnt = r_count;
    assign sum  = {1'b0, i_rdata_a} + {1'b0, i_rdata_b};
    assign diag = {1'b0, ONE_FIXED} + {2'b00, i_rdata_a[WORD_W-1:1]};

    always_comb begin
        o_mem_req.we      = 1'b0;
        o_mem_req.waddr   = {r_n, r_wk};
        o_mem_req.wdata   = r_founder ? '0 : sum[WORD_W:1];
        o_mem_req.raddr_a = pair_addr(r_pa, r_k[IDX_W-1:0]);
        o_mem_req.raddr_b = pair_addr(r_pb, r_k[IDX_W-1:0]);
        case (r_state)
            S_SWEEP: begin
                o_mem_req.we = r_wv;
            end
            S_DIAG_RD, S_Q_RD: begin
                o_mem_req.raddr_a = pair_addr(r_pa, r_pb);
            end
            S_DIAG_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = {r_n, r_n};
                o_mem_req.wdata = r_founder ? ONE_FIXED : diag[WORD_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wv    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_k <= '0;
                        r_wv <= 1'b0;
                        if (i_kind == KIND_QUERY) begin
                            r_pa <= i_first_index;
                            r_pb <= i_second_index;
                            if ({1'b0, i_first_index} >= n_cnt ||
                                {1'b0, i_second_index} >= n_cnt) begin
                                r_res   <= '{'0, i_first_index, ST_BAD_QUERY};
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_Q_RD;
                            end
                        end else if (n_cnt >= MAX_CNT) begin
                            r_res   <= '{'0, '0, ST_FULL};
                            r_state <= S_DONE;
                        end else begin
                            r_n       <= n_cnt[IDX_W-1:0];
                            r_pa      <= i_mother_index;
                            r_pb      <= i_father_index;
                            r_founder <= (n_cnt < i_founder_count);
                            if (n_cnt >= i_founder_count &&
                                ({1'b0, i_mother_index} >= n_cnt ||
                                 {1'b0, i_father_index} >= n_cnt)) begin
                                r_res   <= '{'0, n_cnt[IDX_W-1:0], ST_BAD_PARENT};
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SWEEP;
                            end
                        end
                    end
                end
                S_SWEEP: begin
                    r_wv <= issue;
                    r_wk <= r_k[IDX_W-1:0];
                    if (issue) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_state <= S_DIAG_RD;
                    end
                end
                S_DIAG_RD: begin
                    r_wv    <= 1'b0;
                    r_state <= S_DIAG_WR;
                end
                S_DIAG_WR: begin
                    r_res   <= '{r_founder ? ONE_FIXED : diag[WORD_W-1:0], r_n, ST_OK};
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_Q_RD: begin
                    r_state <= S_Q_DAT;
                end
                S_Q_DAT: begin
                    r_res   <= '{i_rdata_a, r_pa, ST_OK};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// ===== hdl/pedigree_relationship_table_top.sv =====
// Sequence: a query reads the pair and registers the word as its result;
//   an add sweeps row n, then reads the parents' pair and writes the diagonal.
// Throughput: one beat at a time; an add is paced by the row sweep, one
//   entry per cycle through the two read ports and one write port of the store.
// Reset: synchronous, active low; clears the count, sets founder_count to 4,
//   leaves the store contents undefined.
// ----------------------------------------------------------------------------
// pedigree_relationship_table_top
// Additive relationship table with config register and output register.
// ----------------------------------------------------------------------------
module pedigree_relationship_table_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  pedtbl_pkg::t_idx    i_mother_index,
    input  pedtbl_pkg::t_idx    i_father_index,
    input  pedtbl_pkg::t_idx    i_first_index,
    input  pedtbl_pkg::t_idx    i_second_index,
    output logic                o_valid,
    input  logic                i_ready,
    output pedtbl_pkg::t_word   o_relationship,
    output pedtbl_pkg::t_idx    o_assigned_index,
    output pedtbl_pkg::t_status o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  pedtbl_pkg::t_cnt    i_cfg_data
);
    import pedtbl_pkg::*;

    t_cnt     r_founder_count;
    logic     r_o_valid;
    t_result  r_out;
    t_mem_req mem_req;
    t_word    rdata_a;
    t_word    rdata_b;
    logic     res_valid;
    t_result  res;
    logic     res_take;

    assign o_cfg_ready = 1'b1;
    assign res_take    = res_valid && (!r_o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_founder_count <= t_cnt'(4);
            r_o_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_founder_count <= i_cfg_data;
            end
            if (res_take) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    pedtbl_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_mother_index  (i_mother_index),
        .i_father_index  (i_father_index),
        .i_first_index   (i_first_index),
        .i_second_index  (i_second_index),
        .i_founder_count (r_founder_count),
        .o_mem_req       (mem_req),
        .i_rdata_a       (rdata_a),
        .i_rdata_b       (rdata_b),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .i_res_take      (res_take)
    );

    pedtbl_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign o_valid          = r_o_valid;
    assign o_relationship   = r_out.relationship;
    assign o_assigned_index = r_out.assigned_index;
    assign o_status         = r_out.status;

endmodule

// ===== hdl/pedtbl_checker.sv =====
// ----------------------------------------------------------------------------
// pedtbl_checker
// Port-level checks of the relationship table, bound to the top level.
// ----------------------------------------------------------------------------
module pedtbl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input pedtbl_pkg::t_word   o_relationship,
    input pedtbl_pkg::t_idx    o_assigned_index,
    input pedtbl_pkg::t_status o_status
);
    import pedtbl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_relationship) &&
        $stable(o_assigned_index) && $stable(o_status))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again while busy");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_relationship == '0)
        else $error("error beat with nonzero relationship");

    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_assigned_index == '0)
        else $error("table full beat with nonzero index");

endmodule

bind pedigree_relationship_table_top pedtbl_checker u_pedtbl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_relationship   (o_relationship),
    .o_assigned_index (o_assigned_index),
    .o_status         (o_status)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pedigree relationship table. A local copy of the
// table is grown alongside the block: every accepted add or query beat yields
// one awaited result, and each output beat is compared field by field against
// the oldest one. Directed beats cover the reset founder setting, offspring,
// selfing and every error status; random pedigrees under several founder
// settings and stall patterns then fill the table and go past full.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pedtbl_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 16;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    logic    i_kind;
    t_idx    i_mother_index;
    t_idx    i_father_index;
    t_idx    i_first_index;
    t_idx    i_second_index;
    logic    o_valid;
    logic    i_ready = 1'b0;
    t_word   o_relationship;
    t_idx    o_assigned_index;
    t_status o_status;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    t_cnt    i_cfg_data;

    t_word   kinship [MAX_INDIVIDUALS][MAX_INDIVIDUALS];
    int      herd_size;
    int      founder_limit;
    t_result awaited_results [$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      error_count;
    int      cycle_count;

    pedigree_relationship_table_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_mother_index   (i_mother_index),
        .i_father_index   (i_father_index),
        .i_first_index    (i_first_index),
        .i_second_index   (i_second_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_relationship   (o_relationship),
        .o_assigned_index (o_assigned_index),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic t_result predict_relationship(input logic kind, input t_idx mom,
                                                     input t_idx dad, input t_idx first,
                                                     input t_idx second);
        t_result r;
        int      n;
        r = '0;
        if (kind == KIND_QUERY) begin
            r.assigned_index = first;
            if (first >= herd_size || second >= herd_size)
                r.status = ST_BAD_QUERY;
            else
                r.relationship = kinship[first][second];
            return r;
        end
        if (herd_size >= MAX_INDIVIDUALS) begin
            r.status = ST_FULL;
            return r;
        end
        n = herd_size;
        r.assigned_index = t_idx'(n);
        if (n >= founder_limit && (mom >= n || dad >= n)) begin
            r.status = ST_BAD_PARENT;
            return r;
        end
        for (int k = 0; k < n; k++) begin
            if (n < founder_limit)
                kinship[n][k] = '0;
            else
                kinship[n][k] = t_word'(({1'b0, kinship[mom][k]} + {1'b0, kinship[dad][k]}) >> 1);
            kinship[k][n] = kinship[n][k];
        end
        if (n < founder_limit)
            kinship[n][n] = ONE_FIXED;
        else
            kinship[n][n] = ONE_FIXED + (kinship[mom][dad] >> 1);
        herd_size = n + 1;
        r.relationship = kinship[n][n];
        r.status = ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result beat with nothing awaited: assigned_index %0d status %0d",
                       o_assigned_index, o_status);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_relationship !== want.relationship) begin
                    $error("relationship: expected %h, actual %h",
                           want.relationship, o_relationship);
                    error_count++;
                end
                if (o_assigned_index !== want.assigned_index) begin
                    $error("assigned_index: expected %0d, actual %0d",
                           want.assigned_index, o_assigned_index);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    task automatic send_beat(input logic kind, input t_idx mom, input t_idx dad,
                             input t_idx first, input t_idx second);
        t_result predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_mother_index <= mom;
        i_father_index <= dad;
        i_first_index  <= first;
        i_second_index <= second;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_relationship(kind, mom, dad, first, second);
        awaited_results = {awaited_results, predicted};
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_founder_count(input t_cnt value);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        founder_limit = value;
    endtask

    task automatic send_random_beat();
        logic kind;
        t_idx mom;
        t_idx dad;
        t_idx first;
        t_idx second;
        kind   = ($urandom_range(99) < 55) ? KIND_ADD : KIND_QUERY;
        mom    = t_idx'($urandom);
        dad    = t_idx'($urandom);
        first  = t_idx'($urandom);
        second = t_idx'($urandom);
        if (kind == KIND_ADD && herd_size > 0 && $urandom_range(9) != 0) begin
            mom = t_idx'($urandom_range(herd_size - 1));
            dad = ($urandom_range(7) == 0) ? mom : t_idx'($urandom_range(herd_size - 1));
        end
        if (kind == KIND_QUERY && herd_size > 0 && $urandom_range(9) != 0) begin
            first  = t_idx'($urandom_range(herd_size - 1));
            second = t_idx'($urandom_range(herd_size - 1));
        end
        send_beat(kind, mom, dad, first, second);
    endtask

    task automatic run_random_phase(input t_cnt founders, input int send_pct,
                                    input int recv_pct, input int beats,
                                    input bit hold_midway);
        write_founder_count(founders);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < beats; i++) begin
            if (hold_midway && i == beats / 2)
                wait_for_results();
            send_random_beat();
        end
    endtask

    task automatic test_empty_table();
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_default_founders();
        send_beat(KIND_ADD, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_beat(KIND_ADD, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_beat(KIND_ADD, 8'hAA, 8'h55, 8'h55, 8'hAA);
        send_beat(KIND_ADD, 8'h03, 8'h03, 8'h00, 8'h00);
    endtask

    task automatic test_offspring();
        send_beat(KIND_ADD, 8'd0, 8'd1, 8'h00, 8'h00);
        send_beat(KIND_ADD, 8'd4, 8'd4, 8'h00, 8'h00);
        send_beat(KIND_ADD, 8'd5, 8'd2, 8'h00, 8'h00);
        send_beat(KIND_ADD, 8'd5, 8'd4, 8'h00, 8'h00);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd7, 8'd7);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd0, 8'd7);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd7, 8'd0);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd6, 8'd5);
    endtask

    task automatic test_error_status();
        send_beat(KIND_ADD, 8'd8, 8'd0, 8'h00, 8'h00);
        send_beat(KIND_ADD, 8'd0, 8'd255, 8'h00, 8'h00);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd8, 8'd0);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd0, 8'd8);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd255, 8'd255);
    endtask

    task automatic test_random_pedigree();
        run_random_phase(t_cnt'(0), 15, 71, 200, 1'b0);
        run_random_phase(t_cnt'(256), 15, 71, 120, 1'b0);
        run_random_phase(t_cnt'($urandom_range(256)), 71, 15, 200, 1'b1);
        run_random_phase(t_cnt'(255), 71, 15, 200, 1'b0);
        run_random_phase(t_cnt'(3), 0, 0, 280, 1'b0);
    endtask

    task automatic test_table_full();
        while (herd_size < MAX_INDIVIDUALS)
            send_beat(KIND_ADD, t_idx'($urandom_range(herd_size - 1)),
                      t_idx'($urandom_range(herd_size - 1)), 8'h00, 8'h00);
        send_beat(KIND_ADD, 8'd0, 8'd1, 8'h00, 8'h00);
        send_beat(KIND_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd255, 8'd255);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd255, 8'd0);
        send_beat(KIND_QUERY, 8'h00, 8'h00, 8'd0, 8'd255);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_kind         = KIND_ADD;
        i_mother_index = '0;
        i_father_index = '0;
        i_first_index  = '0;
        i_second_index = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        herd_size      = 0;
        founder_limit  = 4;
        send_idle_pct  = 15;
        recv_idle_pct  = 71;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_default_founders();
        test_offspring();
        test_error_status();
        test_random_pedigree();
        test_table_full();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pedtbl_pkg.sv
hdl/pedtbl_mem.sv
hdl/pedtbl_ctrl.sv
hdl/pedigree_relationship_table_top.sv
hdl/pedtbl_checker.sv
tb/tb_top.sv
